// ----- design/lcdlw_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdlw_pkg
// Shared types, constants and the fixed pulse table of the line writer.
// ----------------------------------------------------------------------------
package lcdlw_pkg;

   // panel geometry
   localparam int COLUMNS    = 16;
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int CNT_W      = $clog2(COLUMNS + 1);
   localparam int LAST_PULSE = 2 * COLUMNS + 1;
   localparam int PULSE_W    = $clog2(LAST_PULSE + 1);
   localparam int SHOWN_DEPTH = 2 * (1 << COL_W);
   localparam int SHOWN_AW    = COL_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // panel command bytes
   localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
   localparam logic [7:0] ROW1_OFFSET      = 8'h40;
   localparam logic [3:0] NIB_WAKE         = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;
   localparam logic [7:0] SPACE_CHAR       = 8'h20;

   // timing in microseconds
   localparam logic [15:0] WAIT_POWER_UP_US = 16'd50000;
   localparam logic [12:0] WAIT_BASE_US     = 13'd50;
   localparam logic [12:0] WAIT_WAKE_US     = WAIT_BASE_US + 13'd4500;
   localparam logic [12:0] WAIT_THIRD_US    = WAIT_BASE_US + 13'd150;
   localparam logic [12:0] WAIT_CLEAR_US    = 13'd2050;

   // fixed pulse table layout
   localparam int ROM_W = 5;
   localparam logic [ROM_W-1:0] ROM_INIT_FIRST  = 5'd0;
   localparam logic [ROM_W-1:0] ROM_INIT_LAST   = 5'd13;
   localparam logic [ROM_W-1:0] ROM_CLEAR_FIRST = 5'd14;
   localparam logic [ROM_W-1:0] ROM_CLEAR_LAST  = 5'd15;
   localparam logic [ROM_W-1:0] ROM_SHUT_FIRST  = 5'd16;
   localparam logic [ROM_W-1:0] ROM_SHUT_LAST   = 5'd19;

   typedef enum logic [1:0] {
      REQ_INIT     = 2'd0,
      REQ_CLEAR    = 2'd1,
      REQ_LINE     = 2'd2,
      REQ_SHUTDOWN = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type     kind;
      logic             row;
      logic [CNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic             line_done;
      logic [COL_W-1:0] rd_col;
   } back_status_type;

   typedef struct packed {
      logic        rs;
      logic [3:0]  nibble;
      logic [15:0] pre_wait;
      logic [12:0] after;
   } pulse_type;

   function automatic pulse_type fixed_pulse(input logic [ROM_W-1:0] idx);
      pulse_type p;
      p.rs       = 1'b0;
      p.nibble   = 4'h0;
      p.pre_wait = 16'd0;
      p.after    = WAIT_BASE_US;
      unique case (idx)
         5'd0: begin
            p.nibble   = NIB_WAKE;
            p.pre_wait = WAIT_POWER_UP_US;
            p.after    = WAIT_WAKE_US;
         end
         5'd1: begin
            p.nibble = NIB_WAKE;
            p.after  = WAIT_WAKE_US;
         end
         5'd2: begin
            p.nibble = NIB_WAKE;
            p.after  = WAIT_THIRD_US;
         end
         5'd3:  p.nibble = NIB_FOUR_BIT;
         5'd4:  p.nibble = CMD_FUNCTION_SET[7:4];
         5'd5:  p.nibble = CMD_FUNCTION_SET[3:0];
         5'd6:  p.nibble = CMD_DISPLAY_OFF[7:4];
         5'd7:  p.nibble = CMD_DISPLAY_OFF[3:0];
         5'd8:  p.nibble = CMD_CLEAR[7:4];
         5'd9: begin
            p.nibble = CMD_CLEAR[3:0];
            p.after  = WAIT_CLEAR_US;
         end
         5'd10: p.nibble = CMD_ENTRY_MODE[7:4];
         5'd11: p.nibble = CMD_ENTRY_MODE[3:0];
         5'd12: p.nibble = CMD_DISPLAY_ON[7:4];
         5'd13: p.nibble = CMD_DISPLAY_ON[3:0];
         5'd14: p.nibble = CMD_CLEAR[7:4];
         5'd15: begin
            p.nibble = CMD_CLEAR[3:0];
            p.after  = WAIT_CLEAR_US;
         end
         5'd16: p.nibble = CMD_CLEAR[7:4];
         5'd17: begin
            p.nibble = CMD_CLEAR[3:0];
            p.after  = WAIT_CLEAR_US;
         end
         5'd18: p.nibble = CMD_DISPLAY_OFF[7:4];
         5'd19: p.nibble = CMD_DISPLAY_OFF[3:0];
         default: p.nibble = 4'h0;
      endcase
      return p;
   endfunction

endpackage

// ----- design/lcdlw_ram.sv -----
// ----------------------------------------------------------------------------
// lcdlw_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module lcdlw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/lcdlw_front.sv -----
// ----------------------------------------------------------------------------
// lcdlw_front
// Request intake: gathers line text and queues one command per run.
// ----------------------------------------------------------------------------
module lcdlw_front
   import lcdlw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_type,
   input  logic             req_row,
   input  logic [7:0]       req_char_code,
   input  logic             req_char_valid,
   input  logic             req_last,
   input  queue_status_type qstat,
   output logic             push,
   output cmd_type          push_cmd,
   input  back_status_type  bstat,
   output logic [7:0]       line_char
);

   logic [7:0]       line_ff [COLUMNS];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             accept;
   logic             store;
   logic [CNT_W-1:0] count_upd;
   req_kind_type     kind;

   assign kind      = req_kind_type'(req_type);
   // line items wait while the buffer is still being sent
   assign req_stall = qstat.full || ((kind == REQ_LINE) && busy_ff);
   assign accept    = req_valid && !req_stall;
   assign store     = req_char_valid && (count_ff < CNT_W'(COLUMNS));
   assign count_upd = store ? count_ff + 1'b1 : count_ff;
   assign line_char = line_ff[bstat.rd_col];

   always_comb begin
      count_in       = count_ff;
      busy_in        = busy_ff && !bstat.line_done;
      push           = 1'b0;
      push_cmd.kind  = kind;
      push_cmd.row   = req_row;
      push_cmd.count = count_upd;
      if (accept) begin
         if (kind == REQ_LINE) begin
            count_in = count_upd;
            if (req_last) begin
               push     = 1'b1;
               count_in = '0;
               busy_in  = 1'b1;
            end
         end else begin
            push     = 1'b1;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (kind == REQ_LINE) && store) begin
         line_ff[count_ff[COL_W-1:0]] <= req_char_code;
      end
   end

endmodule

// ----- design/lcdlw_queue.sv -----
// ----------------------------------------------------------------------------
// lcdlw_queue
// Short command queue between intake and pulse sequencer.
// ----------------------------------------------------------------------------
module lcdlw_queue
   import lcdlw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type qstat
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head_cmd    = entry_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- design/lcdlw_back.sv -----
// ----------------------------------------------------------------------------
// lcdlw_back
// Pulse sequencer: fixed command runs, cached-row compare and line sending.
// ----------------------------------------------------------------------------
module lcdlw_back
   import lcdlw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type qstat,
   input  cmd_type          head_cmd,
   output logic             pop,
   output back_status_type  bstat,
   input  logic [7:0]       line_char,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_rs_level,
   output logic [3:0]       rsp_nibble,
   output logic [15:0]      rsp_wait_before_us,
   output logic [12:0]      rsp_wait_after_us,
   output logic             rsp_end_of_run
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIXED,
      ST_CMP_RD,
      ST_CMP_CHK,
      ST_SEND
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         shown_ff, shown_in;
   logic               row_ff, row_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [PULSE_W-1:0] pulse_ff, pulse_in;
   logic [ROM_W-1:0]   rom_ff, rom_in;
   logic [ROM_W-1:0]   rom_end_ff, rom_end_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pulse_type          rsp_ff, rsp_in;
   logic               rsp_end_ff, rsp_end_in;

   logic               out_free;
   logic [COL_W-1:0]   send_col;
   logic [COL_W-1:0]   rd_col;
   logic [7:0]         padded;
   logic [7:0]         tx_byte;
   logic               ram_we;
   logic [7:0]         ram_rdata;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign send_col = COL_W'((pulse_ff - PULSE_W'(2)) >> 1);
   assign rd_col   = (state_ff == ST_SEND) ? send_col : col_ff;
   assign padded   = (CNT_W'(rd_col) < count_ff) ? line_char : SPACE_CHAR;
   assign tx_byte  = (pulse_ff < PULSE_W'(2)) ?
                     (CMD_SET_DDRAM | (row_ff ? ROW1_OFFSET : 8'h00)) : padded;

   lcdlw_ram #(
      .WIDTH (8),
      .DEPTH (SHOWN_DEPTH)
   ) u_shown (
      .clock (clock),
      .we    (ram_we),
      .waddr ({row_ff, send_col}),
      .wdata (padded),
      .raddr ({row_ff, col_ff}),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in        = state_ff;
      shown_in        = shown_ff;
      row_in          = row_ff;
      count_in        = count_ff;
      col_in          = col_ff;
      pulse_in        = pulse_ff;
      rom_in          = rom_ff;
      rom_end_in      = rom_end_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_in          = rsp_ff;
      rsp_end_in      = rsp_end_ff;
      pop             = 1'b0;
      ram_we          = 1'b0;
      bstat.line_done = 1'b0;
      bstat.rd_col    = rd_col;

      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               row_in   = head_cmd.row;
               count_in = head_cmd.count;
               col_in   = '0;
               pulse_in = '0;
               unique case (head_cmd.kind)
                  REQ_INIT: begin
                     shown_in   = 2'b00;
                     rom_in     = ROM_INIT_FIRST;
                     rom_end_in = ROM_INIT_LAST;
                     state_in   = ST_FIXED;
                  end
                  REQ_CLEAR: begin
                     shown_in   = 2'b00;
                     rom_in     = ROM_CLEAR_FIRST;
                     rom_end_in = ROM_CLEAR_LAST;
                     state_in   = ST_FIXED;
                  end
                  REQ_SHUTDOWN: begin
                     shown_in   = 2'b00;
                     rom_in     = ROM_SHUT_FIRST;
                     rom_end_in = ROM_SHUT_LAST;
                     state_in   = ST_FIXED;
                  end
                  REQ_LINE: begin
                     state_in = shown_ff[head_cmd.row] ? ST_CMP_RD : ST_SEND;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FIXED: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = fixed_pulse(rom_ff);
               rsp_end_in   = (rom_ff == rom_end_ff);
               rom_in       = rom_ff + 1'b1;
               if (rom_ff == rom_end_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CMP_RD: begin
            state_in = ST_CMP_CHK;
         end
         ST_CMP_CHK: begin
            if (ram_rdata != padded) begin
               state_in = ST_SEND;
            end else if (col_ff == COL_W'(COLUMNS - 1)) begin
               bstat.line_done = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_CMP_RD;
            end
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.rs       = (pulse_ff >= PULSE_W'(2));
               rsp_in.nibble   = pulse_ff[0] ? tx_byte[3:0] : tx_byte[7:4];
               rsp_in.pre_wait = 16'd0;
               rsp_in.after    = WAIT_BASE_US;
               rsp_end_in      = (pulse_ff == PULSE_W'(LAST_PULSE));
               // refresh the cached row as each low nibble leaves
               ram_we          = pulse_ff[0] && (pulse_ff >= PULSE_W'(2));
               pulse_in        = pulse_ff + 1'b1;
               if (pulse_ff == PULSE_W'(LAST_PULSE)) begin
                  shown_in[row_ff] = 1'b1;
                  bstat.line_done  = 1'b1;
                  state_in         = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shown_ff     <= 2'b00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shown_ff     <= shown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff     <= row_in;
      count_ff   <= count_in;
      col_ff     <= col_in;
      pulse_ff   <= pulse_in;
      rom_ff     <= rom_in;
      rom_end_ff <= rom_end_in;
      rsp_ff     <= rsp_in;
      rsp_end_ff <= rsp_end_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rs_level       = rsp_ff.rs;
   assign rsp_nibble         = rsp_ff.nibble;
   assign rsp_wait_before_us = rsp_ff.pre_wait;
   assign rsp_wait_after_us  = rsp_ff.after;
   assign rsp_end_of_run     = rsp_end_ff;

endmodule

// ----- design/char_lcd_nibble_line_writer_core.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_line_writer_core
// Host side of a 4-bit character panel link: one transaction out per enable pulse.
// ----------------------------------------------------------------------------
// Requests (init, clear, shutdown, line character) enter on the req_ channel;
// every rsp_ transaction is one enable pulse with its RS level, nibble and the
// waits around it, and end_of_run marks the last pulse of a request. A line
// character that is not marked last is only gathered. Init, clear and shutdown
// are played from a fixed table at one pulse per cycle while the output is
// taken (14, 2 and 4 pulses). A line end first checks the cached row when it
// is valid, a read state then a check state per column through the registered
// read of the shown-text RAM, and unless it matches sends 2*COLUMNS+2 pulses at
// one per cycle while the output is taken. A two-entry command queue lets the
// intake keep accepting while pulses go out; a full queue holds off every
// request; line characters also wait until the prior line is sent or skipped.
// No clearing pass after reset: per-row valid bits mark the cache empty.
// ----------------------------------------------------------------------------
module char_lcd_nibble_line_writer_core
   import lcdlw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic        req_row,
   input  logic [7:0]  req_char_code,
   input  logic        req_char_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_rs_level,
   output logic [3:0]  rsp_nibble,
   output logic [15:0] rsp_wait_before_us,
   output logic [12:0] rsp_wait_after_us,
   output logic        rsp_end_of_run
);

   queue_status_type qstat;
   back_status_type  bstat;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             push;
   logic             pop;
   logic [7:0]       line_char;

   // intake: classify requests, gather line text
   lcdlw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_row        (req_row),
      .req_char_code  (req_char_code),
      .req_char_valid (req_char_valid),
      .req_last       (req_last),
      .qstat          (qstat),
      .push           (push),
      .push_cmd       (push_cmd),
      .bstat          (bstat),
      .line_char      (line_char)
   );

   // decouple intake from pulse generation
   lcdlw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .qstat    (qstat)
   );

   // sequencer: fixed runs, row compare, line send, output register
   lcdlw_back u_back (
      .clock              (clock),
      .reset              (reset),
      .qstat              (qstat),
      .head_cmd           (head_cmd),
      .pop                (pop),
      .bstat              (bstat),
      .line_char          (line_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rs_level       (rsp_rs_level),
      .rsp_nibble         (rsp_nibble),
      .rsp_wait_before_us (rsp_wait_before_us),
      .rsp_wait_after_us  (rsp_wait_after_us),
      .rsp_end_of_run     (rsp_end_of_run)
   );

endmodule

// ----- design/lcdlw_checker.sv -----
// ----------------------------------------------------------------------------
// lcdlw_checker
// Port-level checks on the line writer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdlw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_type,
   input logic        req_row,
   input logic [7:0]  req_char_code,
   input logic        req_char_valid,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_rs_level,
   input logic [3:0]  rsp_nibble,
   input logic [15:0] rsp_wait_before_us,
   input logic [12:0] rsp_wait_after_us,
   input logic        rsp_end_of_run
);

   // stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_nibble)
         && $stable(rsp_rs_level) && $stable(rsp_end_of_run))
      else $error("rsp transaction changed under stall");

   // data pulses never carry a leading wait
   a_data_no_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rs_level |-> rsp_wait_before_us == 16'd0
         && rsp_wait_after_us == 13'd50)
      else $error("data pulse with non-default waits");

   // hold-off is one of the known values
   a_after_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wait_after_us == 13'd50 || rsp_wait_after_us == 13'd200
         || rsp_wait_after_us == 13'd2050 || rsp_wait_after_us == 13'd4550)
      else $error("unexpected hold-off value");

   // power-up wait only on the first wake nibble
   a_power_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wait_before_us != 16'd0 |-> rsp_nibble == 4'h3
         && !rsp_rs_level && rsp_wait_after_us == 13'd4550 && !rsp_end_of_run)
      else $error("power-up wait on wrong pulse");

endmodule

bind char_lcd_nibble_line_writer_core lcdlw_checker u_lcdlw_checker (.*);

// ----- bench/lcd_pulse_checker.sv -----
// ----------------------------------------------------------------------------
// lcd_pulse_checker
// Watches both channels of the line writer, predicts every enable pulse and
// compares each accepted response transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module lcd_pulse_checker
   import lcdlw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic              req_row,
   input  logic [7:0]        req_char_code,
   input  logic              req_char_valid,
   input  logic              req_last,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_rs_level,
   input  logic [3:0]        rsp_nibble,
   input  logic [15:0]       rsp_wait_before_us,
   input  logic [12:0]       rsp_wait_after_us,
   input  logic              rsp_end_of_run,
   output int unsigned       mismatch_count,
   output int unsigned       pulses_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0]  BYTE_FUNCTION_SET = 8'h28;
   localparam logic [7:0]  BYTE_DISPLAY_OFF  = 8'h08;
   localparam logic [7:0]  BYTE_CLEAR        = 8'h01;
   localparam logic [7:0]  BYTE_ENTRY_MODE   = 8'h06;
   localparam logic [7:0]  BYTE_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0]  BYTE_DDRAM_ADDR   = 8'h80;
   localparam logic [7:0]  BYTE_ROW1_BASE    = 8'h40;
   localparam logic [7:0]  BYTE_SPACE        = 8'h20;
   localparam logic [3:0]  NIBBLE_WAKE       = 4'h3;
   localparam logic [3:0]  NIBBLE_FOUR_BIT   = 4'h2;
   localparam logic [15:0] US_POWER_UP       = 16'd50000;
   localparam logic [12:0] US_BASE           = 13'd50;
   localparam logic [12:0] US_WAKE           = 13'd4550;
   localparam logic [12:0] US_THIRD_WAKE     = 13'd200;
   localparam logic [12:0] US_CLEAR          = 13'd2050;

   typedef struct packed {
      logic        rs;
      logic [3:0]  nibble;
      logic [15:0] pre_wait;
      logic [12:0] after;
      logic        end_of_run;
   } lcd_pulse_type;

   logic [7:0]    shown_text [2][COLUMNS];
   logic [1:0]    row_shown;
   logic [7:0]    gathered_text [COLUMNS];
   int unsigned   gathered_count;
   logic          gathered_row;
   lcd_pulse_type expected_pulses [$];

   function automatic void push_pulse(input logic rs, input logic [3:0] nibble,
                                      input logic [15:0] pre_wait,
                                      input logic [12:0] after);
      lcd_pulse_type p;
      p.rs         = rs;
      p.nibble     = nibble;
      p.pre_wait   = pre_wait;
      p.after      = after;
      p.end_of_run = 1'b0;
      expected_pulses.push_back(p);
   endfunction

   function automatic void push_byte(input logic rs, input logic [7:0] value,
                                     input logic [12:0] after_low);
      push_pulse(rs, value[7:4], 16'd0, US_BASE);
      push_pulse(rs, value[3:0], 16'd0, after_low);
   endfunction

   function automatic void predict_pulses(input req_kind_type kind, input logic row,
                                          input logic [7:0] code, input logic char_ok,
                                          input logic is_last);
      logic [7:0]    line [COLUMNS];
      int unsigned   queued_before;
      logic          unchanged;
      lcd_pulse_type tail;
      queued_before = expected_pulses.size();
      case (kind)
         REQ_INIT: begin
            gathered_count = 0;
            row_shown      = 2'b00;
            push_pulse(1'b0, NIBBLE_WAKE, US_POWER_UP, US_WAKE);
            push_pulse(1'b0, NIBBLE_WAKE, 16'd0, US_WAKE);
            push_pulse(1'b0, NIBBLE_WAKE, 16'd0, US_THIRD_WAKE);
            push_pulse(1'b0, NIBBLE_FOUR_BIT, 16'd0, US_BASE);
            push_byte(1'b0, BYTE_FUNCTION_SET, US_BASE);
            push_byte(1'b0, BYTE_DISPLAY_OFF, US_BASE);
            push_byte(1'b0, BYTE_CLEAR, US_CLEAR);
            push_byte(1'b0, BYTE_ENTRY_MODE, US_BASE);
            push_byte(1'b0, BYTE_DISPLAY_ON, US_BASE);
         end
         REQ_CLEAR: begin
            gathered_count = 0;
            row_shown      = 2'b00;
            push_byte(1'b0, BYTE_CLEAR, US_CLEAR);
         end
         REQ_SHUTDOWN: begin
            gathered_count = 0;
            row_shown      = 2'b00;
            push_byte(1'b0, BYTE_CLEAR, US_CLEAR);
            push_byte(1'b0, BYTE_DISPLAY_OFF, US_BASE);
         end
         default: begin
            gathered_row = row;
            if (char_ok && gathered_count < COLUMNS) begin
               gathered_text[gathered_count] = code;
               gathered_count++;
            end
            if (is_last) begin
               for (int i = 0; i < COLUMNS; i++)
                  line[i] = (i < gathered_count) ? gathered_text[i] : BYTE_SPACE;
               gathered_count = 0;
               unchanged = row_shown[gathered_row];
               for (int i = 0; i < COLUMNS; i++)
                  if (line[i] != shown_text[gathered_row][i]) unchanged = 1'b0;
               if (!unchanged) begin
                  for (int i = 0; i < COLUMNS; i++) shown_text[gathered_row][i] = line[i];
                  row_shown[gathered_row] = 1'b1;
                  push_byte(1'b0, BYTE_DDRAM_ADDR | (gathered_row ? BYTE_ROW1_BASE : 8'h00),
                            US_BASE);
                  for (int i = 0; i < COLUMNS; i++) push_byte(1'b1, line[i], US_BASE);
               end
            end
         end
      endcase
      if (expected_pulses.size() > queued_before) begin
         tail = expected_pulses.pop_back();
         tail.end_of_run = 1'b1;
         expected_pulses.push_back(tail);
      end
   endfunction

   always @(posedge clock) begin
      lcd_pulse_type seen;
      lcd_pulse_type want;
      if (reset) begin
         for (int r = 0; r < 2; r++)
            for (int i = 0; i < COLUMNS; i++) shown_text[r][i] = 8'h00;
         row_shown      = 2'b00;
         gathered_count = 0;
         gathered_row   = 1'b0;
         expected_pulses.delete();
         mismatch_count = 0;
      end else begin
         // compare first, so a response can never match a prediction made at the same edge
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            seen = '{rsp_rs_level, rsp_nibble, rsp_wait_before_us, rsp_wait_after_us,
                     rsp_end_of_run};
            if (expected_pulses.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected pulse rs=%0d nibble=%h before=%0d after=%0d end=%0d",
                           $time, seen.rs, seen.nibble, seen.pre_wait, seen.after,
                           seen.end_of_run);
               mismatch_count++;
            end else begin
               want = expected_pulses.pop_front();
               if (seen.rs !== want.rs || seen.nibble !== want.nibble ||
                   seen.pre_wait !== want.pre_wait || seen.after !== want.after ||
                   seen.end_of_run !== want.end_of_run) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: pulse mismatch expected rs=%0d nibble=%h before=%0d after=%0d end=%0d",
                              $time, want.rs, want.nibble, want.pre_wait, want.after,
                              want.end_of_run);
                     $display("%0t:                     got rs=%0d nibble=%h before=%0d after=%0d end=%0d",
                              $time, seen.rs, seen.nibble, seen.pre_wait, seen.after,
                              seen.end_of_run);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            predict_pulses(req_kind_type'(req_type), req_row, req_char_code,
                           req_char_valid, req_last);
      end
      pulses_pending = expected_pulses.size();
   end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the 4-bit character panel line writer.
// ----------------------------------------------------------------------------
// A directed opening covers init, clear, shutdown, cached-row skips, padding
// equality, empty lines, row switching and lines cut short by other requests.
// Random lines follow in five phases with different idling on both sides and
// one long receiver hold-off that backs the block up to its input. The
// checker beside the block predicts every pulse and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lcdlw_pkg::*;

   localparam int MAX_LINE       = COLUMNS + 4;   // longest text offered, to force truncation
   localparam int RANDOM_ITEMS   = 150;
   localparam int PHASES         = 5;
   localparam int HOLD_OFF_TICKS = 400;
   localparam int DRAIN_TICKS    = 200;
   localparam int CYCLE_LIMIT    = 300000;

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type       = REQ_CLEAR;
   logic        req_row        = 1'b0;
   logic [7:0]  req_char_code  = 8'h00;
   logic        req_char_valid = 1'b0;
   logic        req_last       = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic        rsp_rs_level;
   logic [3:0]  rsp_nibble;
   logic [15:0] rsp_wait_before_us;
   logic [12:0] rsp_wait_after_us;
   logic        rsp_end_of_run;

   int unsigned mismatch_count;
   int unsigned pulses_pending;

   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   logic        hold_off_go   = 1'b0;
   logic        hold_off_done = 1'b0;
   int          hold_left     = 0;
   int          cycle_count   = 0;
   int          items_sent    = 0;

   logic [7:0]  line_buf [MAX_LINE];
   int          line_len;
   logic [7:0]  prior_line [2][MAX_LINE];
   int          prior_len [2] = '{-1, -1};

   char_lcd_nibble_line_writer_core u_top (.*);
   lcd_pulse_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Receiver: hold off once for a long stretch when asked, otherwise stall at random.
   always @(posedge clock) begin
      if (hold_off_go && !hold_off_done) begin
         hold_off_done <= 1'b1;
         hold_left     <= HOLD_OFF_TICKS;
         rsp_stall     <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one request transaction and hold it until the block takes it.
   task automatic send_request(input req_kind_type kind, input logic row,
                               input logic [7:0] code, input logic char_ok,
                               input logic is_last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_row        <= row;
      req_char_code  <= code;
      req_char_valid <= char_ok;
      req_last       <= is_last;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
   endtask

   function automatic void load_text(input string s);
      line_len = s.len();
      for (int i = 0; i < s.len(); i++) line_buf[i] = s[i];
   endfunction

   // Stream line_buf as one line; the end marker closes it with a char-less item.
   // Row noise flips the row of middle items and drops in char-less items.
   task automatic send_line(input logic row, input bit end_marker, input bit row_noise);
      logic item_row;
      bit   closes;
      for (int i = 0; i < line_len; i++) begin
         closes = (i == line_len - 1) && !end_marker;
         if (row_noise && $urandom_range(9) == 0)
            send_request(REQ_LINE, 1'($urandom_range(1)), 8'($urandom_range(255)),
                         1'b0, 1'b0);
         item_row = row;
         if (row_noise && !closes && $urandom_range(3) == 0) item_row = ~row;
         send_request(REQ_LINE, item_row, line_buf[i], 1'b1, closes);
      end
      if (end_marker || line_len == 0)
         send_request(REQ_LINE, row, 8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   task automatic send_control();
      req_kind_type kind;
      case ($urandom_range(2))
         0:       kind = REQ_INIT;
         1:       kind = REQ_CLEAR;
         default: kind = REQ_SHUTDOWN;
      endcase
      send_request(kind, 1'($urandom_range(1)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic random_request();
      int   pick;
      int   shape;
      logic row;
      pick = $urandom_range(99);
      row  = 1'($urandom_range(1));
      if (pick < 8) begin
         send_control();
      end else if (pick < 13) begin
         // broken line: a few characters, then another request drops them
         repeat ($urandom_range(1, 4))
            send_request(REQ_LINE, 1'($urandom_range(1)), 8'($urandom_range(255)),
                         1'($urandom_range(1)), 1'b0);
         send_control();
      end else begin
         if (prior_len[row] >= 0 && $urandom_range(99) < 25) begin
            // replay the row's last text, sometimes with trailing spaces up to full width
            line_len = prior_len[row];
            for (int i = 0; i < line_len; i++) line_buf[i] = prior_line[row][i];
            if ($urandom_range(1) == 1)
               while (line_len < COLUMNS) begin
                  line_buf[line_len] = 8'h20;
                  line_len++;
               end
         end else begin
            shape = $urandom_range(99);
            if (shape < 5)       line_len = 0;
            else if (shape < 12) line_len = $urandom_range(COLUMNS + 1, MAX_LINE);
            else if (shape < 20) line_len = COLUMNS;
            else                 line_len = $urandom_range(1, 6);
            for (int i = 0; i < line_len; i++) line_buf[i] = 8'($urandom_range(255));
         end
         send_line(row, $urandom_range(9) == 0, 1'b1);
         prior_len[row] = line_len;
         for (int i = 0; i < line_len; i++) prior_line[row][i] = line_buf[i];
      end
   endtask

   initial begin
      int directed_items;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      send_request(REQ_INIT, 1'b1, 8'hA5, 1'b1, 1'b1);
      load_text("AB");
      send_line(1'b0, 1'b0, 1'b0);              // written
      send_line(1'b0, 1'b0, 1'b0);              // same text: skipped
      load_text("AB   ");
      send_line(1'b0, 1'b0, 1'b0);              // equal once padded: skipped
      load_text("");
      send_line(1'b1, 1'b0, 1'b0);              // empty line: all spaces
      send_line(1'b1, 1'b0, 1'b0);              // skipped
      send_request(REQ_LINE, 1'b0, 8'h00, 1'b1, 1'b0);
      send_request(REQ_LINE, 1'b1, 8'hFF, 1'b1, 1'b1);  // row of the final item wins
      send_request(REQ_LINE, 1'b1, 8'h5A, 1'b0, 1'b0);  // no character: row only
      send_request(REQ_LINE, 1'b0, 8'h41, 1'b1, 1'b1);
      send_request(REQ_LINE, 1'b0, 8'h55, 1'b1, 1'b0);
      send_request(REQ_CLEAR, 1'b1, 8'hAA, 1'b0, 1'b0); // drops the partial line
      send_request(REQ_LINE, 1'b1, 8'h33, 1'b1, 1'b0);
      send_request(REQ_INIT, 1'b0, 8'h0F, 1'b1, 1'b0);
      send_request(REQ_LINE, 1'b0, 8'hC3, 1'b1, 1'b0);
      send_request(REQ_SHUTDOWN, 1'b0, 8'hF0, 1'b0, 1'b1);
      load_text("Z");
      send_line(1'b1, 1'b1, 1'b0);              // closed by an end marker
      send_request(REQ_CLEAR, 1'b0, 8'h81, 1'b1, 1'b1);
      directed_items = items_sent;

      // random phases: none, sender idle, receiver stall, both, none
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1:       begin send_idle_pct = 55; rsp_stall_pct <= 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct <= 55; end
            3:       begin send_idle_pct = 20; rsp_stall_pct <= 20; end
            default: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
         endcase
         if (phase == 0) hold_off_go <= 1'b1;
         while (items_sent < directed_items + (phase + 1) * RANDOM_ITEMS / PHASES)
            random_request();
      end

      // drain: drop valid, let every predicted pulse arrive, then watch for strays
      req_valid     <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      while (pulses_pending != 0) @(negedge clock);
      repeat (DRAIN_TICKS) @(negedge clock);

      if (mismatch_count == 0 && pulses_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/lcdlw_pkg.sv
design/lcdlw_ram.sv
design/lcdlw_front.sv
design/lcdlw_queue.sv
design/lcdlw_back.sv
design/char_lcd_nibble_line_writer_core.sv
design/lcdlw_checker.sv
bench/lcd_pulse_checker.sv
bench/testbench.sv
